// ----- rtl/atb_pkg.sv -----
package atb_pkg;

	localparam int MAX_GRID_DEF = 64;
	localparam int MAX_TILE_DEF = 256;

	localparam int GRID_CFG_W = 7;
	localparam int TILE_CFG_W = 9;
	localparam int PITCH_W    = 15;
	localparam int CAP_W      = 13;
	localparam int ID_W       = 12;
	localparam int ADDR_W     = 28;
	localparam int PIXEL_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam int ROW_PROD_W = GRID_CFG_W + PITCH_W;
	localparam int COL_PROD_W = GRID_CFG_W + TILE_CFG_W;
	localparam int Y_PROD_W   = TILE_CFG_W + PITCH_W;
	localparam int BASE_W     = ROW_PROD_W + TILE_CFG_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLUMNS,
		REG_GRID_ROWS,
		REG_TILE_WIDTH,
		REG_TILE_HEIGHT,
		REG_ROW_PITCH,
		REG_TILE_CAPACITY
	} cfg_reg_t;

	// Clamped dimensions plus raw pitch and capacity
	typedef struct packed {
		logic [GRID_CFG_W-1:0] cols;
		logic [GRID_CFG_W-1:0] rows;
		logic [TILE_CFG_W-1:0] tw;
		logic [TILE_CFG_W-1:0] th;
		logic [PITCH_W-1:0]    pitch;
		logic [CAP_W-1:0]      capacity;
	} cfg_t;

	// Placement of one pixel, handed from the counters to the address pipeline
	typedef struct packed {
		logic [PIXEL_W-1:0]    pixel;
		logic [GRID_CFG_W-1:0] frow;
		logic [GRID_CFG_W-1:0] col;
		logic [TILE_CFG_W-1:0] px;
		logic [TILE_CFG_W-1:0] py;
		logic [ID_W-1:0]       id;
		logic                  we;
		logic                  done;
		logic                  full;
	} place_t;

endpackage

// ----- rtl/atb_cfg.sv -----
module atb_cfg #(
	parameter int MAX_GRID = atb_pkg::MAX_GRID_DEF,
	parameter int MAX_TILE = atb_pkg::MAX_TILE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [atb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [atb_pkg::CFG_DATA_W-1:0]   cfg_data,
	output atb_pkg::cfg_t                    cfg
);
	import atb_pkg::*;

	localparam int GRID_LIM = (MAX_GRID < 127) ? MAX_GRID : 127;
	localparam int TILE_LIM = (MAX_TILE < 511) ? MAX_TILE : 511;

	logic [GRID_CFG_W-1:0] grid_columns_q;
	logic [GRID_CFG_W-1:0] grid_rows_q;
	logic [TILE_CFG_W-1:0] tile_width_q;
	logic [TILE_CFG_W-1:0] tile_height_q;
	logic [PITCH_W-1:0]    row_pitch_q;
	logic [CAP_W-1:0]      tile_capacity_q;

	function automatic logic [GRID_CFG_W-1:0] clamp_grid(input logic [GRID_CFG_W-1:0] v);
		logic [GRID_CFG_W-1:0] r;
		if (v == '0)
			r = GRID_CFG_W'(1);
		else if (v > GRID_CFG_W'(GRID_LIM))
			r = GRID_CFG_W'(GRID_LIM);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [TILE_CFG_W-1:0] clamp_tile(input logic [TILE_CFG_W-1:0] v);
		logic [TILE_CFG_W-1:0] r;
		if (v == '0)
			r = TILE_CFG_W'(1);
		else if (v > TILE_CFG_W'(TILE_LIM))
			r = TILE_CFG_W'(TILE_LIM);
		else
			r = v;
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q  <= GRID_CFG_W'(1);
			grid_rows_q     <= GRID_CFG_W'(1);
			tile_width_q    <= TILE_CFG_W'(1);
			tile_height_q   <= TILE_CFG_W'(1);
			row_pitch_q     <= PITCH_W'(1);
			tile_capacity_q <= CAP_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_COLUMNS:  grid_columns_q  <= cfg_data[GRID_CFG_W-1:0];
				REG_GRID_ROWS:     grid_rows_q     <= cfg_data[GRID_CFG_W-1:0];
				REG_TILE_WIDTH:    tile_width_q    <= cfg_data[TILE_CFG_W-1:0];
				REG_TILE_HEIGHT:   tile_height_q   <= cfg_data[TILE_CFG_W-1:0];
				REG_ROW_PITCH:     row_pitch_q     <= cfg_data[PITCH_W-1:0];
				REG_TILE_CAPACITY: tile_capacity_q <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.cols     = clamp_grid(grid_columns_q);
		cfg.rows     = clamp_grid(grid_rows_q);
		cfg.tw       = clamp_tile(tile_width_q);
		cfg.th       = clamp_tile(tile_height_q);
		cfg.pitch    = row_pitch_q;
		cfg.capacity = tile_capacity_q;
	end

endmodule

// ----- rtl/atb_place.sv -----
module atb_place #(
	parameter int MAX_GRID = atb_pkg::MAX_GRID_DEF,
	parameter int MAX_TILE = atb_pkg::MAX_TILE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  atb_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [atb_pkg::PIXEL_W-1:0]   pixel_in,
	output logic                          valid_s1,
	output atb_pkg::place_t               place_s1,
	input  logic                          s1_stall
);
	import atb_pkg::*;

	localparam int GRID_LIM = (MAX_GRID < 127) ? MAX_GRID : 127;
	localparam int TILE_LIM = (MAX_TILE < 511) ? MAX_TILE : 511;
	localparam int CW = (GRID_LIM > 1) ? $clog2(GRID_LIM) : 1;
	localparam int PW = (TILE_LIM > 1) ? $clog2(TILE_LIM) : 1;

	logic [CAP_W-1:0] tiles_used_q;
	logic [CW-1:0]    cell_column_q;
	logic [CW-1:0]    cell_row_q;
	logic [PW-1:0]    pixel_x_q;
	logic [PW-1:0]    pixel_y_q;

	logic                  accept;
	logic                  full;
	logic                  last_x;
	logic                  last_y;
	logic                  last_col;
	logic [TILE_CFG_W:0]   px_inc;
	logic [TILE_CFG_W:0]   py_inc;
	logic [GRID_CFG_W:0]   col_inc;
	logic [CW-1:0]         row_inc;
	logic [GRID_CFG_W-1:0] frow;
	place_t                place_d;

	assign in_stall = valid_s1 && s1_stall;
	assign accept   = in_valid && !in_stall;

	assign full = (tiles_used_q >= cfg.capacity)
		|| (GRID_CFG_W'(cell_row_q) >= cfg.rows);

	// A counter left beyond a smaller limit counts as its last position
	assign px_inc   = {1'b0, TILE_CFG_W'(pixel_x_q)} + (TILE_CFG_W+1)'(1);
	assign py_inc   = {1'b0, TILE_CFG_W'(pixel_y_q)} + (TILE_CFG_W+1)'(1);
	assign col_inc  = {1'b0, GRID_CFG_W'(cell_column_q)} + (GRID_CFG_W+1)'(1);
	assign last_x   = px_inc >= {1'b0, cfg.tw};
	assign last_y   = py_inc >= {1'b0, cfg.th};
	assign last_col = col_inc >= {1'b0, cfg.cols};
	assign row_inc  = cell_row_q + CW'(1);
	assign frow     = cfg.rows - GRID_CFG_W'(1) - GRID_CFG_W'(cell_row_q);

	always_comb begin
		place_d.pixel = pixel_in;
		place_d.full  = full;
		place_d.we    = !full;
		place_d.done  = !full && last_x && last_y;
		place_d.frow  = full ? '0 : frow;
		place_d.col   = full ? '0 : GRID_CFG_W'(cell_column_q);
		place_d.px    = full ? '0 : TILE_CFG_W'(pixel_x_q);
		place_d.py    = full ? '0 : TILE_CFG_W'(pixel_y_q);
		place_d.id    = full ? '0 : tiles_used_q[ID_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			tiles_used_q  <= '0;
			cell_column_q <= '0;
			cell_row_q    <= '0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (!s1_stall)
				valid_s1 <= 1'b0;

			// Once full, hold every counter
			if (accept && !full) begin
				if (!last_x) begin
					pixel_x_q <= px_inc[PW-1:0];
				end else begin
					pixel_x_q <= '0;
					if (!last_y) begin
						pixel_y_q <= py_inc[PW-1:0];
					end else begin
						pixel_y_q    <= '0;
						tiles_used_q <= tiles_used_q + CAP_W'(1);
						if (last_col) begin
							cell_column_q <= '0;
							// Hold at the top row when the row counter wraps
							cell_row_q    <= (row_inc == '0) ? '1 : row_inc;
						end else begin
							cell_column_q <= col_inc[CW-1:0];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			place_s1 <= place_d;
	end

endmodule

// ----- rtl/atb_addr.sv -----
module atb_addr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  atb_pkg::cfg_t                 cfg,
	input  logic                          valid_s1,
	input  atb_pkg::place_t               place_s1,
	output logic                          s1_stall,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [atb_pkg::ADDR_W-1:0]    write_address,
	output logic [atb_pkg::PIXEL_W-1:0]   pixel_out,
	output logic                          write_enable,
	output logic [atb_pkg::ID_W-1:0]      tile_id,
	output logic                          tile_done,
	output logic                          full_error
);
	import atb_pkg::*;

	logic                  valid_s2;
	logic [ROW_PROD_W-1:0] row_prod_s2;
	logic [COL_PROD_W-1:0] col_prod_s2;
	logic [Y_PROD_W-1:0]   y_prod_s2;
	logic [TILE_CFG_W-1:0] px_s2;
	logic [PIXEL_W-1:0]    pixel_s2;
	logic [ID_W-1:0]       id_s2;
	logic                  we_s2;
	logic                  done_s2;
	logic                  full_s2;

	logic                  valid_s3;
	logic [ADDR_W-1:0]     addr_s3;
	logic [PIXEL_W-1:0]    pixel_s3;
	logic [ID_W-1:0]       id_s3;
	logic                  we_s3;
	logic                  done_s3;
	logic                  full_s3;

	logic                  s3_open;
	logic                  s2_open;
	logic                  load_s2;
	logic                  load_s3;
	logic [ROW_PROD_W-1:0] row_mul;
	logic [COL_PROD_W-1:0] col_mul;
	logic [Y_PROD_W-1:0]   y_mul;
	logic [BASE_W-1:0]     base_mul;
	logic [ADDR_W-1:0]     addr_sum;

	assign s3_open  = !valid_s3 || !out_stall;
	assign s2_open  = !valid_s2 || s3_open;
	assign s1_stall = !s2_open;
	assign load_s2  = valid_s1 && s2_open;
	assign load_s3  = valid_s2 && s3_open;

	assign row_mul = {{PITCH_W{1'b0}}, place_s1.frow} * {{GRID_CFG_W{1'b0}}, cfg.pitch};
	assign col_mul = {{TILE_CFG_W{1'b0}}, place_s1.col} * {{GRID_CFG_W{1'b0}}, cfg.tw};
	assign y_mul   = {{PITCH_W{1'b0}}, place_s1.py} * {{TILE_CFG_W{1'b0}}, cfg.pitch};

	assign base_mul = {{TILE_CFG_W{1'b0}}, row_prod_s2} * {{ROW_PROD_W{1'b0}}, cfg.th};
	// Sum wraps at the address width
	assign addr_sum = base_mul[ADDR_W-1:0]
		+ ADDR_W'(col_prod_s2)
		+ ADDR_W'(y_prod_s2)
		+ ADDR_W'(px_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_open)
				valid_s2 <= valid_s1;
			if (s3_open)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			row_prod_s2 <= row_mul;
			col_prod_s2 <= col_mul;
			y_prod_s2   <= y_mul;
			px_s2       <= place_s1.px;
			pixel_s2    <= place_s1.pixel;
			id_s2       <= place_s1.id;
			we_s2       <= place_s1.we;
			done_s2     <= place_s1.done;
			full_s2     <= place_s1.full;
		end
		if (load_s3) begin
			addr_s3  <= addr_sum;
			pixel_s3 <= pixel_s2;
			id_s3    <= id_s2;
			we_s3    <= we_s2;
			done_s3  <= done_s2;
			full_s3  <= full_s2;
		end
	end

	assign out_valid     = valid_s3;
	assign write_address = addr_s3;
	assign pixel_out     = pixel_s3;
	assign write_enable  = we_s3;
	assign tile_id       = id_s3;
	assign tile_done     = done_s3;
	assign full_error    = full_s3;

endmodule

// ----- rtl/atlas_tile_blit_address_top.sv -----
// Atlas write-address generator: feed the pixels of equal-size tiles in row-major order, one
// transaction per pixel; each pixel leaves with its atlas address, tile id, a last-pixel mark and
// a full flag. One pixel is taken every cycle while the output is not stalled; each result passes
// through registers holding the placement counters' output, then the row, column and y
// products, then the row-base product and the final sum, and up to three pixels are in flight.
// Grid and tile sizes are clamped to the supported range; write the registers only with no
// pixel in flight.
module atlas_tile_blit_address_top #(
	parameter int MAX_GRID = atb_pkg::MAX_GRID_DEF,
	parameter int MAX_TILE = atb_pkg::MAX_TILE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [atb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [atb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [atb_pkg::PIXEL_W-1:0]   pixel_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [atb_pkg::ADDR_W-1:0]    write_address,
	output logic [atb_pkg::PIXEL_W-1:0]   pixel_out,
	output logic                          write_enable,
	output logic [atb_pkg::ID_W-1:0]      tile_id,
	output logic                          tile_done,
	output logic                          full_error
);
	import atb_pkg::*;

	cfg_t   cfg;
	place_t place_s1;
	logic   valid_s1;
	logic   s1_stall;

	atb_cfg #(
		.MAX_GRID (MAX_GRID),
		.MAX_TILE (MAX_TILE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	atb_place #(
		.MAX_GRID (MAX_GRID),
		.MAX_TILE (MAX_TILE)
	) u_place (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pixel_in (pixel_in),
		.valid_s1 (valid_s1),
		.place_s1 (place_s1),
		.s1_stall (s1_stall)
	);

	atb_addr u_addr (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.valid_s1      (valid_s1),
		.place_s1      (place_s1),
		.s1_stall      (s1_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.write_address (write_address),
		.pixel_out     (pixel_out),
		.write_enable  (write_enable),
		.tile_id       (tile_id),
		.tile_done     (tile_done),
		.full_error    (full_error)
	);

	// Input backs up only when every stage holds a pixel
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_we_excl_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_enable != full_error))
		else $error("write enable and full flag disagree");

	a_full_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && full_error) |->
			(write_address == '0 && tile_id == '0 && !tile_done))
		else $error("full result carries placement fields");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(place_s1)))
		else $error("stalled pipeline dropped a pixel");

endmodule
